@@ rtl/core/xxtea_pkg.sv @@
// Shared types, constants and helpers for the XXTEA block cipher core
package xxtea_pkg;

  localparam int unsigned MAX_WORDS_DEF = 64;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned ROUNDS_BASE = 6;

  localparam logic [CFG_IDX_W-1:0] REG_KEY0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DELTA = 3'd4;

  localparam logic [31:0] KEY0_RST  = 32'h0000_BEDC;
  localparam logic [31:0] KEY1_RST  = 32'h0000_32FB;
  localparam logic [31:0] KEY2_RST  = 32'h0000_F3AD;
  localparam logic [31:0] KEY3_RST  = 32'h0000_E24F;
  localparam logic [31:0] DELTA_RST = 32'h9EBC_A9B9;

  localparam logic OP_ENC = 1'b0;
  localparam logic OP_DEC = 1'b1;

  typedef logic [3:0][31:0] key_t;

  typedef struct packed {
    logic        operation;
    logic [31:0] word;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] word_res;
    logic        last_res;
    logic        overflow;
  } out_item_t;

  typedef struct packed {
    logic [31:0] cur;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] sum;
    logic [1:0]  pos;
    logic        decrypt;
  } round_in_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_INIT,
    S_PREV,
    S_RD,
    S_UPD,
    S_ORD,
    S_OSHOW,
    S_OWAIT
  } state_t;

  // 52 / n for a block of n words
  function automatic logic [5:0] rounds_extra(input logic [31:0] n);
    logic [5:0] r;
    case (n) inside
      32'd1:          r = 6'd52;
      32'd2:          r = 6'd26;
      32'd3:          r = 6'd17;
      32'd4:          r = 6'd13;
      32'd5:          r = 6'd10;
      32'd6:          r = 6'd8;
      32'd7:          r = 6'd7;
      32'd8:          r = 6'd6;
      [32'd9:32'd10]:  r = 6'd5;
      [32'd11:32'd13]: r = 6'd4;
      [32'd14:32'd17]: r = 6'd3;
      [32'd18:32'd26]: r = 6'd2;
      [32'd27:32'd52]: r = 6'd1;
      default:        r = 6'd0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/xxtea_block_cipher_core.sv @@
// XXTEA block cipher core: block load, in-place round sequencer, word unload
//
//   channel  | signals                              | direction
//   data     | data_valid, data_stall, data_item    | words in, last word closes block
//   result   | result_valid, result_stall, result_item | processed words out
//   cfg      | cfg_we, cfg_index, cfg_data          | key words and delta, write only
//
// Load takes one word per cycle. Processing of an n-word block runs S_INIT,
// S_PREV, then 6 + 52/n rounds of n word updates through the shared round
// unit, each update an S_RD/S_UPD pair set by the store's registered reads.
// Unload: S_ORD, S_OSHOW, S_OWAIT per word; S_OWAIT holds on result_stall.
// Reset is synchronous; the word store needs no clearing pass.
module xxtea_block_cipher_core #(
  parameter int unsigned MAX_WORDS = xxtea_pkg::MAX_WORDS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                data_valid,
  output logic                                data_stall,
  input  xxtea_pkg::in_item_t                 data_item,
  output logic                                result_valid,
  input  logic                                result_stall,
  output xxtea_pkg::out_item_t                result_item,
  input  logic                                cfg_we,
  input  logic [xxtea_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                         cfg_data
);
  import xxtea_pkg::*;

  localparam int unsigned AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int unsigned CW = $clog2(MAX_WORDS + 1);

  state_t         state;
  state_t         state_next;
  key_t           key;
  logic [31:0]    delta;
  logic [CW-1:0]  count;
  logic           ovf;
  logic           op;
  logic [CW-1:0]  n;
  logic [5:0]     rounds;
  logic [31:0]    sum;
  logic [31:0]    prev;
  logic [AW-1:0]  p;
  logic [AW-1:0]  k;

  logic           data_accept;
  logic           room;
  logic [AW-1:0]  last_idx;
  logic [AW-1:0]  nb_idx;
  logic           round_end;
  logic [31:0]    dec_sum;
  logic           mem_we;
  logic [AW-1:0]  waddr;
  logic [31:0]    wdata;
  logic [AW-1:0]  raddr_a;
  logic [31:0]    rd_a;
  logic [31:0]    rd_b;
  round_in_t      ri;
  logic [31:0]    upd_res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key[0] <= KEY0_RST;
      key[1] <= KEY1_RST;
      key[2] <= KEY2_RST;
      key[3] <= KEY3_RST;
      delta  <= DELTA_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY0:  key[0] <= cfg_data;
        REG_KEY1:  key[1] <= cfg_data;
        REG_KEY2:  key[2] <= cfg_data;
        REG_KEY3:  key[3] <= cfg_data;
        REG_DELTA: delta  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign data_accept = data_valid && !data_stall;
  assign room        = (count != CW'(MAX_WORDS));
  assign last_idx    = AW'(n - CW'(1));
  assign round_end   = (op == OP_DEC) ? (p == '0) : (p == last_idx);
  assign dec_sum     = {26'd0, rounds} * delta;

  always_comb begin
    if (op == OP_DEC) begin
      nb_idx = (p == '0) ? last_idx : (p - AW'(1));
    end else begin
      nb_idx = (p == last_idx) ? '0 : (p + AW'(1));
    end
  end

  always_comb begin
    ri.cur     = rd_a;
    ri.y       = (op == OP_DEC) ? prev : rd_b;
    ri.z       = (op == OP_DEC) ? rd_b : prev;
    ri.sum     = sum;
    ri.pos     = 2'(p);
    ri.decrypt = (op == OP_DEC);
  end

  xxtea_round u_round (
    .ri  (ri),
    .key (key),
    .res (upd_res)
  );

  xxtea_mem #(
    .DEPTH (MAX_WORDS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (nb_idx),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    data_stall = 1'b1;
    mem_we     = 1'b0;
    waddr      = p;
    wdata      = upd_res;
    raddr_a    = p;
    unique case (state)
      S_LOAD: begin
        data_stall = 1'b0;
        mem_we     = data_accept && room;
        waddr      = AW'(count);
        wdata      = data_item.word;
        if (data_accept && data_item.last) begin
          state_next = S_INIT;
        end
      end
      S_INIT: begin
        raddr_a    = (op == OP_DEC) ? '0 : last_idx;
        state_next = S_PREV;
      end
      S_PREV: begin
        state_next = S_RD;
      end
      S_RD: begin
        state_next = S_UPD;
      end
      S_UPD: begin
        mem_we = 1'b1;
        if (round_end && rounds == 6'd1) begin
          state_next = S_ORD;
        end else begin
          state_next = S_RD;
        end
      end
      S_ORD: begin
        raddr_a    = k;
        state_next = S_OSHOW;
      end
      S_OSHOW: begin
        state_next = S_OWAIT;
      end
      S_OWAIT: begin
        if (!result_stall) begin
          state_next = (k == last_idx) ? S_LOAD : S_ORD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      ovf          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          if (data_accept) begin
            if (room) begin
              count <= count + CW'(1);
            end else begin
              ovf <= 1'b1;
            end
          end
        end
        S_OSHOW: result_valid <= 1'b1;
        S_OWAIT: begin
          if (!result_stall) begin
            result_valid <= 1'b0;
            if (k == last_idx) begin
              count <= '0;
              ovf   <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_LOAD: begin
        if (data_accept && data_item.last) begin
          op <= data_item.operation;
          n  <= room ? (count + CW'(1)) : count;
        end
      end
      S_INIT: rounds <= 6'(ROUNDS_BASE) + rounds_extra(32'(n));
      S_PREV: begin
        prev <= rd_a;
        sum  <= (op == OP_DEC) ? dec_sum : delta;
        p    <= (op == OP_DEC) ? last_idx : '0;
      end
      S_UPD: begin
        prev <= upd_res;
        k    <= '0;
        if (round_end) begin
          rounds <= rounds - 6'd1;
          if (op == OP_DEC) begin
            p   <= last_idx;
            sum <= sum - delta;
          end else begin
            p   <= '0;
            sum <= sum + delta;
          end
        end else if (op == OP_DEC) begin
          p <= p - AW'(1);
        end else begin
          p <= p + AW'(1);
        end
      end
      S_OSHOW: begin
        result_item.word_res <= rd_a;
        result_item.last_res <= (k == last_idx);
        result_item.overflow <= ovf;
      end
      S_OWAIT: begin
        if (!result_stall) begin
          k <= k + AW'(1);
        end
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_valid_in_wait: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (state == S_OWAIT))
    else $error("result valid outside unload wait");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_WORDS))
    else $error("word count beyond store depth");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    ovf |-> (count == CW'(MAX_WORDS)))
    else $error("overflow flagged with store not full");

  a_rounds_live: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD) |-> (rounds != 6'd0))
    else $error("word update issued with no rounds left");

  a_block_done: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_stall && result_item.last_res)
      |=> (state == S_LOAD && count == '0 && !ovf))
    else $error("block state not cleared after final item");
`endif

endmodule

@@ rtl/core/xxtea_mem.sv @@
// Block word store: one write port, two registered read ports
module xxtea_mem #(
  parameter int unsigned DEPTH = xxtea_pkg::MAX_WORDS_DEF,
  parameter int unsigned AW = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [31:0]   rdata_a,
  output logic [31:0]   rdata_b
);
  import xxtea_pkg::*;

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

@@ rtl/core/xxtea_round.sv @@
// XXTEA word update: mix function and add or subtract into the current word
module xxtea_round (
  input  xxtea_pkg::round_in_t ri,
  input  xxtea_pkg::key_t      key,
  output logic [31:0]          res
);
  import xxtea_pkg::*;

  logic [31:0] a;
  logic [31:0] b;
  logic [31:0] c;
  logic [31:0] d;
  logic [31:0] m;
  logic [1:0]  ksel;

  always_comb begin
    a    = (ri.z >> 5) ^ (ri.y << 2);
    b    = (ri.y >> 3) ^ (ri.z << 4);
    c    = ri.sum ^ ri.y;
    ksel = ri.pos ^ ri.sum[3:2];
    d    = key[ksel] ^ ri.z;
    m    = (a + b) ^ (c + d);
    res  = ri.decrypt ? (ri.cur - m) : (ri.cur + m);
  end

endmodule
